/* src/vcsl_pkg.sv */
// Package of the velocity command slew limiter: payload structs, pipeline
// depths, fixed-point constants and the step functions of the root and divider.
// No dependencies.
package vcsl_pkg;

  // Widths of the values.
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned STEP_W    = 31;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 32;
  localparam int unsigned SQ_W      = 64;
  localparam int unsigned T_W       = 33;
  localparam int unsigned PROD_W    = VAL_W + T_W;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_LINEAR_STEP  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGULAR_STEP = 8'd1;

  localparam logic [STEP_W-1:0] STEP_RESET = 31'd1048576;

  // Epsilon is 10 LSB, so its square is 100.
  localparam logic [VAL_W-1:0] EPS    = 32'd10;
  localparam logic [SQ_W-1:0]  EPS_SQ = 64'd100;

  // Pipeline depths.
  localparam int unsigned ISQRT_STEPS     = 32;
  localparam int unsigned ISQRT_PER_STAGE = 2;
  localparam int unsigned ISQRT_STAGES    = ISQRT_STEPS / ISQRT_PER_STAGE;
  localparam int unsigned DIV_STEPS       = 32;
  localparam int unsigned DIV_PER_STAGE   = 2;
  localparam int unsigned DIV_STAGES      = DIV_STEPS / DIV_PER_STAGE;
  localparam int unsigned LATENCY         = ISQRT_STAGES + DIV_STAGES + 5;

  typedef struct packed {
    logic signed [VAL_W-1:0] cmd_vx;
    logic signed [VAL_W-1:0] cmd_vy;
    logic signed [VAL_W-1:0] cmd_wz;
    logic signed [VAL_W-1:0] cur_vx;
    logic signed [VAL_W-1:0] cur_vy;
    logic signed [VAL_W-1:0] cur_wz;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] lim_vx;
    logic signed [VAL_W-1:0] lim_vy;
    logic signed [VAL_W-1:0] lim_wz;
  } out_item_t;

  typedef struct packed {
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] root;
  } sqrt_st_t;

  typedef struct packed {
    logic [VAL_W-1:0] rem;
    logic [VAL_W-1:0] quo;
  } div_st_t;

  // Magnitude of a signed value; the most negative value maps to 2^31.
  function automatic logic [VAL_W-1:0] mag(input logic [VAL_W-1:0] v);
    mag = v[VAL_W-1] ? (~v + 1'b1) : v;
  endfunction

  // One step of the digit-by-digit square root.
  function automatic sqrt_st_t sqrt_step(input sqrt_st_t s, input logic [SQ_W-1:0] b);
    sqrt_st_t o;
    logic [SQ_W-1:0] trial;
    trial = s.root + b;
    if (s.rem >= trial) begin
      o.rem  = s.rem - trial;
      o.root = (s.root >> 1) + b;
    end else begin
      o.rem  = s.rem;
      o.root = s.root >> 1;
    end
    return o;
  endfunction

  // One step of restoring division: the next dividend bit enters from quo.
  function automatic div_st_t div_step(input div_st_t s, input logic [VAL_W-1:0] den);
    div_st_t o;
    logic [VAL_W:0] r2;
    logic ge;
    r2 = {s.rem, s.quo[VAL_W-1]};
    ge = (r2 >= {1'b0, den});
    o.rem = ge ? VAL_W'(r2 - {1'b0, den}) : r2[VAL_W-1:0];
    o.quo = {s.quo[VAL_W-2:0], ge};
    return o;
  endfunction

endpackage

/* src/vcsl_isqrt_pipe.sv */
// Pipelined integer square root of a 64-bit radicand, two bits of root per stage.
// Depends on vcsl_pkg.
module vcsl_isqrt_pipe (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [vcsl_pkg::SQ_W-1:0] rad_i,
  output logic [vcsl_pkg::VAL_W-1:0] root_o
);
  import vcsl_pkg::*;

  sqrt_st_t st_q [ISQRT_STAGES];

  for (genvar s = 0; s < ISQRT_STAGES; s++) begin : g_stage
    sqrt_st_t st_in;
    sqrt_st_t st_mid;
    sqrt_st_t st_d;
    localparam int unsigned K0 = s * ISQRT_PER_STAGE;
    localparam logic [SQ_W-1:0] B0 = SQ_W'(64'd1 << (62 - 2 * K0));
    localparam logic [SQ_W-1:0] B1 = SQ_W'(64'd1 << (60 - 2 * K0));

    if (s == 0) begin : g_first
      assign st_in = '{rem: rad_i, root: '0};
    end else begin : g_next
      assign st_in = st_q[s-1];
    end

    assign st_mid = sqrt_step(st_in, B0);
    assign st_d   = sqrt_step(st_mid, B1);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[s] <= st_d;
      end
    end
  end

  assign root_o = st_q[ISQRT_STAGES-1].root[VAL_W-1:0];

endmodule

/* src/vcsl_div_pipe.sv */
// Pipelined restoring divider, 65-bit dividend by 32-bit divisor, two quotient
// bits per stage, with a flag for quotients of 2^32 and above. Depends on vcsl_pkg.
module vcsl_div_pipe (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [vcsl_pkg::PROD_W-1:0] num_i,
  input  logic [vcsl_pkg::VAL_W-1:0]  den_i,
  output logic [vcsl_pkg::VAL_W-1:0]  quo_o,
  output logic                        ovf_o
);
  import vcsl_pkg::*;

  div_st_t          st_q  [DIV_STAGES];
  logic [VAL_W-1:0] den_q [DIV_STAGES];
  logic             ovf_q [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    div_st_t          st_in;
    div_st_t          st_mid;
    div_st_t          st_d;
    logic [VAL_W-1:0] den_in;
    logic             ovf_in;

    if (s == 0) begin : g_first
      assign st_in  = '{rem: num_i[2*VAL_W-1:VAL_W], quo: num_i[VAL_W-1:0]};
      assign den_in = den_i;
      // The quotient needs more than 32 bits when the top part reaches the divisor.
      assign ovf_in = (num_i[PROD_W-1:VAL_W] >= {1'b0, den_i});
    end else begin : g_next
      assign st_in  = st_q[s-1];
      assign den_in = den_q[s-1];
      assign ovf_in = ovf_q[s-1];
    end

    assign st_mid = div_step(st_in, den_in);
    assign st_d   = div_step(st_mid, den_in);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[s]  <= st_d;
        den_q[s] <= den_in;
        ovf_q[s] <= ovf_in;
      end
    end
  end

  assign quo_o = st_q[DIV_STAGES-1].quo;
  assign ovf_o = ovf_q[DIV_STAGES-1];

endmodule

/* src/velocity_command_slew_limiter_core.sv */
// Top level of the velocity command slew limiter: input, output and
// configuration channels and the pipeline. Depends on vcsl_pkg,
// vcsl_isqrt_pipe and vcsl_div_pipe.
//
// Usage
// -----
// A command item (commanded and measured x, y and angular velocity, all
// signed Q11.20) is transferred on the input channel when in_valid_i and
// in_ready_o are both high. Exactly one limited command leaves on the output
// channel, in order, when out_valid_o and out_ready_i are both high.
// The pipeline is 37 register stages deep: two for the squares and their
// sums, sixteen for the two square roots, two for the case selection and the
// rescaling products, sixteen for the dividers and one output register.
// While the output is not stalled, one item can be transferred in every
// cycle; the throughput is one item per cycle.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ready_o drops in the same cycle, so nothing is lost or repeated.
// Bubbles behind a stalled result are not squeezed out.
// The configuration channel is always ready; its writes take effect at once
// and must be made while no item is in flight. A write to an unknown index
// is ignored.
// Reset clears all valid bits and sets both step limits to 1.0 (2^20 LSB).
module velocity_command_slew_limiter_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  vcsl_pkg::in_item_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output vcsl_pkg::out_item_t            out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [vcsl_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [vcsl_pkg::CFG_DAT_W-1:0] cfg_data_i
);
  import vcsl_pkg::*;

  // Sideband that travels alongside the square roots.
  typedef struct packed {
    logic             tiny;
    logic             pass;
    logic [VAL_W-1:0] cmd_x;
    logic [VAL_W-1:0] cmd_y;
    logic [VAL_W-1:0] cur_x;
    logic [VAL_W-1:0] cur_y;
    logic [VAL_W-1:0] wz;
  } sqrt_sb_t;

  // Sideband that travels alongside the dividers.
  typedef struct packed {
    logic             neg_x;
    logic             neg_y;
    logic             scale;
    logic [VAL_W-1:0] cmd_x;
    logic [VAL_W-1:0] cmd_y;
    logic [VAL_W-1:0] wz;
  } div_sb_t;

  // Configuration registers.
  logic [STEP_W-1:0] lin_max_q, ang_max_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lin_max_q <= STEP_RESET;
      ang_max_q <= STEP_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_LINEAR_STEP:  lin_max_q <= cfg_data_i[STEP_W-1:0];
        REG_ANGULAR_STEP: ang_max_q <= cfg_data_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline advances unless a finished result is held back.
  logic             en;
  logic [LATENCY-1:0] vld_q;

  assign en         = !vld_q[LATENCY-1] || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LATENCY-2:0], in_valid_i};
    end
  end

  // Stage 1: squares of the magnitudes and the angular clamp.
  logic [SQ_W-1:0]  sq_cx_q, sq_cy_q, sq_ux_q, sq_uy_q;
  logic [VAL_W-1:0] s1_cx_q, s1_cy_q, s1_cw_q, s1_ux_q, s1_uy_q, s1_wz_q;
  logic             s1_wtiny_q;

  logic [VAL_W-1:0]      m_cx, m_cy, m_ux, m_uy;
  logic signed [VAL_W:0] dw, amax_s;
  logic signed [VAL_W+1:0] w_up, w_dn;
  logic [VAL_W-1:0]      wz_lim;

  // Clamp a 34-bit signed value into the 32-bit signed range.
  function automatic logic [VAL_W-1:0] sat_wide(input logic signed [VAL_W+1:0] v);
    logic signed [VAL_W+1:0] hi, lo;
    hi = (VAL_W+2)'(34'sh0_7FFF_FFFF);
    lo = -(VAL_W+2)'(34'sh0_8000_0000);
    if (v > hi)      sat_wide = 32'h7FFF_FFFF;
    else if (v < lo) sat_wide = 32'h8000_0000;
    else             sat_wide = v[VAL_W-1:0];
  endfunction

  always_comb begin
    m_cx   = mag(in_data_i.cmd_vx);
    m_cy   = mag(in_data_i.cmd_vy);
    m_ux   = mag(in_data_i.cur_vx);
    m_uy   = mag(in_data_i.cur_vy);
    amax_s = $signed({2'b00, ang_max_q});
    dw     = $signed({in_data_i.cmd_wz[VAL_W-1], in_data_i.cmd_wz})
           - $signed({in_data_i.cur_wz[VAL_W-1], in_data_i.cur_wz});
    w_up   = $signed({{2{in_data_i.cur_wz[VAL_W-1]}}, in_data_i.cur_wz})
           + $signed({3'b000, ang_max_q});
    w_dn   = $signed({{2{in_data_i.cur_wz[VAL_W-1]}}, in_data_i.cur_wz})
           - $signed({3'b000, ang_max_q});
    if (dw > amax_s)       wz_lim = sat_wide(w_up);
    else if (-dw > amax_s) wz_lim = sat_wide(w_dn);
    else                   wz_lim = in_data_i.cmd_wz;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_cx_q    <= {32'b0, m_cx} * {32'b0, m_cx};
      sq_cy_q    <= {32'b0, m_cy} * {32'b0, m_cy};
      sq_ux_q    <= {32'b0, m_ux} * {32'b0, m_ux};
      sq_uy_q    <= {32'b0, m_uy} * {32'b0, m_uy};
      s1_cx_q    <= in_data_i.cmd_vx;
      s1_cy_q    <= in_data_i.cmd_vy;
      s1_cw_q    <= in_data_i.cmd_wz;
      s1_ux_q    <= in_data_i.cur_vx;
      s1_uy_q    <= in_data_i.cur_vy;
      s1_wz_q    <= wz_lim;
      s1_wtiny_q <= (mag(in_data_i.cmd_wz) < EPS);
    end
  end

  // Stage 2: squared norms and the full-stop test.
  logic [SQ_W-1:0] sq_cmd_q, sq_cur_q;
  sqrt_sb_t        s2_sb_q;
  logic [SQ_W-1:0] sq_cmd_d;
  logic            tiny_d, pass_d;

  assign sq_cmd_d = sq_cx_q + sq_cy_q;
  assign tiny_d   = (sq_cmd_d < EPS_SQ);
  assign pass_d   = tiny_d && s1_wtiny_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_cmd_q <= sq_cmd_d;
      sq_cur_q <= sq_ux_q + sq_uy_q;
      // A full stop passes the commanded angular velocity unchanged.
      s2_sb_q  <= '{tiny: tiny_d, pass: pass_d, cmd_x: s1_cx_q, cmd_y: s1_cy_q,
                    cur_x: s1_ux_q, cur_y: s1_uy_q,
                    wz: (pass_d ? s1_cw_q : s1_wz_q)};
    end
  end

  // Square roots of both norms, with the sideband delayed to match.
  logic [VAL_W-1:0] n_cmd, n_cur;
  sqrt_sb_t         sqrt_sb_q [ISQRT_STAGES];

  vcsl_isqrt_pipe u_sqrt_cmd (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (sq_cmd_q),
    .root_o (n_cmd)
  );

  vcsl_isqrt_pipe u_sqrt_cur (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (sq_cur_q),
    .root_o (n_cur)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqrt_sb_q[0] <= s2_sb_q;
      for (int i = 1; i < ISQRT_STAGES; i++) begin
        sqrt_sb_q[i] <= sqrt_sb_q[i-1];
      end
    end
  end

  // Stage 3: choose between rise, fall and within limit, and the target norm.
  sqrt_sb_t         sb3;
  logic [VAL_W+1:0] cur_plus, cmd_plus;
  logic             rise, fall, use_cur;
  logic [VAL_W-1:0] src_x, src_y;

  logic [VAL_W-1:0] s3_mx_q, s3_my_q, s3_den_q;
  logic [T_W-1:0]   s3_t_q;
  div_sb_t          s3_sb_q;

  assign sb3      = sqrt_sb_q[ISQRT_STAGES-1];
  assign cur_plus = {2'b00, n_cur} + {3'b000, lin_max_q};
  assign cmd_plus = {2'b00, n_cmd} + {3'b000, lin_max_q};
  assign rise     = ({2'b00, n_cmd} > cur_plus);
  assign fall     = ({2'b00, n_cur} > cmd_plus);
  // A falling command that is itself tiny shrinks the measured vector instead.
  assign use_cur  = fall && !rise && sb3.tiny;
  assign src_x    = use_cur ? sb3.cur_x : sb3.cmd_x;
  assign src_y    = use_cur ? sb3.cur_y : sb3.cmd_y;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_mx_q  <= mag(src_x);
      s3_my_q  <= mag(src_y);
      s3_den_q <= use_cur ? n_cur : n_cmd;
      s3_t_q   <= rise ? cur_plus[T_W-1:0]
                       : T_W'({1'b0, n_cur} - {2'b00, lin_max_q});
      s3_sb_q  <= '{neg_x: src_x[VAL_W-1], neg_y: src_y[VAL_W-1],
                    scale: (!sb3.pass && (rise || fall)),
                    cmd_x: sb3.cmd_x, cmd_y: sb3.cmd_y, wz: sb3.wz};
    end
  end

  // Stage 4: numerators of the rescaling.
  logic [PROD_W-1:0] s4_px_q, s4_py_q;
  logic [VAL_W-1:0]  s4_den_q;
  div_sb_t           div_sb_q [DIV_STAGES+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_px_q     <= {{T_W{1'b0}}, s3_mx_q} * {{VAL_W{1'b0}}, s3_t_q};
      s4_py_q     <= {{T_W{1'b0}}, s3_my_q} * {{VAL_W{1'b0}}, s3_t_q};
      s4_den_q    <= s3_den_q;
      div_sb_q[0] <= s3_sb_q;
      for (int i = 1; i <= DIV_STAGES; i++) begin
        div_sb_q[i] <= div_sb_q[i-1];
      end
    end
  end

  // Dividers, one for each linear component.
  logic [VAL_W-1:0] q_x, q_y;
  logic             ovf_x, ovf_y;

  vcsl_div_pipe u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (s4_px_q),
    .den_i (s4_den_q),
    .quo_o (q_x),
    .ovf_o (ovf_x)
  );

  vcsl_div_pipe u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (s4_py_q),
    .den_i (s4_den_q),
    .quo_o (q_y),
    .ovf_o (ovf_y)
  );

  // Output stage: clamp the quotient, restore the sign and saturate.
  function automatic logic [VAL_W-1:0] signed_sat(input logic [VAL_W-1:0] q,
                                                 input logic ovf, input logic neg);
    logic [VAL_W-1:0] qq;
    qq = (ovf || (q > 32'h8000_0000)) ? 32'h8000_0000 : q;
    if (neg)                     signed_sat = ~qq + 1'b1;
    else if (qq == 32'h8000_0000) signed_sat = 32'h7FFF_FFFF;
    else                         signed_sat = qq;
  endfunction

  div_sb_t   sb5;
  out_item_t out_q;

  assign sb5 = div_sb_q[DIV_STAGES];

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.lim_vx <= sb5.scale ? signed_sat(q_x, ovf_x, sb5.neg_x) : sb5.cmd_x;
      out_q.lim_vy <= sb5.scale ? signed_sat(q_y, ovf_y, sb5.neg_y) : sb5.cmd_y;
      out_q.lim_wz <= sb5.wz;
    end
  end

  assign out_valid_o = vld_q[LATENCY-1];
  assign out_data_o  = out_q;

endmodule

/* src/vcsl_checker.sv */
// Port-level checker of the velocity command slew limiter and its bind.
// Depends on vcsl_pkg and velocity_command_slew_limiter_core.
module vcsl_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input vcsl_pkg::out_item_t out_data_o,
  input logic                cfg_ready_o
);
  import vcsl_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its value.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  // A stalled output freezes the pipeline, so no transfer is taken in.
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while output stalled");

  // With no result waiting, the block always takes a transfer.
  a_free_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o && cfg_ready_o)
    else $error("block not ready although output is empty");

endmodule

bind velocity_command_slew_limiter_core vcsl_checker u_vcsl_checker (.*);
